// ----- src/ehph_pkg.sv -----
package ehph_pkg;

  // Field and register widths fixed by the block's definition.
  localparam int ANGLE_W    = 9;
  localparam int BAND_W     = 4;
  localparam int DUTY_W     = 8;
  localparam int SCALE_W    = 16;
  localparam int FRAC_W     = 16;
  localparam int MODE_W     = 2;
  localparam int PHASE_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Result queue depth; a power of two.
  localparam int OUT_Q_DEPTH = 4;

  // Item kinds carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_EDGE_A = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EDGE_B = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ANGLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_DUTY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOME_DUTY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE        = 3'd4;

  // Register values after reset.
  localparam logic [ANGLE_W-1:0] TARGET_ANGLE_RST = 9'd45;
  localparam logic [BAND_W-1:0]  DEADBAND_RST     = 4'd2;
  localparam logic [DUTY_W-1:0]  DRIVE_DUTY_RST   = 8'd25;
  localparam logic [DUTY_W-1:0]  HOME_DUTY_RST    = 8'd25;
  localparam logic [SCALE_W-1:0] SCALE_RST        = 16'd39361;

  // Controller phase, one-hot internally.
  typedef enum logic [2:0] {
    PH_HOMING  = 3'b001,
    PH_ARMING  = 3'b010,
    PH_HOLDING = 3'b100
  } phase_t;

  // Phase codes as reported on the result channel.
  localparam logic [PHASE_W-1:0] PHASE_CODE_HOMING  = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_CODE_ARMING  = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_CODE_HOLDING = 2'd2;

  function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
    logic [PHASE_W-1:0] code;
    case (ph)
      PH_HOMING:  code = PHASE_CODE_HOMING;
      PH_ARMING:  code = PHASE_CODE_ARMING;
      PH_HOLDING: code = PHASE_CODE_HOLDING;
      default:    code = PHASE_CODE_HOMING;
    endcase
    return code;
  endfunction

endpackage

// ----- src/ehph_if.sv -----
// Input channel: one edge or tick event per transaction.
interface ehph_in_if;
  logic                          valid;
  logic                          ready;
  logic [ehph_pkg::MODE_W-1:0]   mode;
  logic                          level_a;
  logic                          level_b;
  logic                          home_switch;

  modport source (output valid, mode, level_a, level_b, home_switch, input ready);
  modport sink   (input valid, mode, level_a, level_b, home_switch, output ready);
endinterface

// Result channel: drive state and position after each event.
interface ehph_out_if #(parameter int POSITION_WIDTH = 24);
  logic                                valid;
  logic                                ready;
  logic                                direction;
  logic [ehph_pkg::DUTY_W-1:0]         duty;
  logic [ehph_pkg::PHASE_W-1:0]        phase;
  logic signed [POSITION_WIDTH-1:0]    position;

  modport source (output valid, direction, duty, phase, position, input ready);
  modport sink   (input valid, direction, duty, phase, position, output ready);
endinterface

// Configuration write channel.
interface ehph_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ehph_pkg::CFG_IDX_W-1:0]    index;
  logic [ehph_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/ehph_out_q.sv -----
module ehph_out_q #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 4,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int LVL_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data,
  output logic [LVL_W-1:0] level
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic             pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (level_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign level     = level_r;

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    level_nxt  = level_r + LVL_W'(push) - LVL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // The producer's credit check must keep the queue from overflowing.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (level_r != LVL_W'(DEPTH)) || pop)
    else $error("result queue written while full");

endmodule

// ----- src/ehph_core.sv -----
module ehph_core #(
  parameter int POSITION_WIDTH = 24,
  localparam int LVL_W  = $clog2(ehph_pkg::OUT_Q_DEPTH + 1),
  localparam int RES_W  = 1 + ehph_pkg::DUTY_W + ehph_pkg::PHASE_W + POSITION_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  ehph_in_if.sink          in_chan,
  ehph_cfg_if.sink         cfg_chan,
  input  logic [LVL_W-1:0] q_level,
  output logic             res_push,
  output logic [RES_W-1:0] res_data
);

  localparam int PW     = POSITION_WIDTH;
  localparam int PROD_W = PW + ehph_pkg::SCALE_W + 1;
  localparam int ERR_W  = PROD_W + 1;
  localparam int TGT_W  = ehph_pkg::ANGLE_W + ehph_pkg::FRAC_W;
  localparam int BQ_W   = ehph_pkg::BAND_W + ehph_pkg::FRAC_W;
  localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW - 1){1'b1}}};
  localparam logic signed [PW-1:0] POS_MIN = {1'b1, {(PW - 1){1'b0}}};

  // Configuration registers.
  logic [ehph_pkg::ANGLE_W-1:0] target_r;
  logic [ehph_pkg::BAND_W-1:0]  band_r;
  logic [ehph_pkg::DUTY_W-1:0]  drive_duty_r;
  logic [ehph_pkg::DUTY_W-1:0]  home_duty_r;
  logic [ehph_pkg::SCALE_W-1:0] scale_r;
  logic                         recalc_r;

  // Input register.
  logic                         item_v_r, item_v_nxt;
  logic [ehph_pkg::MODE_W-1:0]  mode_r;
  logic                         lvl_a_r;
  logic                         lvl_b_r;
  logic                         switch_r;

  // Controller state; prod_r tracks count_r times the scale.
  logic signed [PW-1:0]         count_r, count_nxt;
  logic signed [PROD_W-1:0]     prod_r, prod_nxt;
  ehph_pkg::phase_t             phase_r, phase_nxt;
  logic                         dir_r, dir_nxt;
  logic [ehph_pkg::DUTY_W-1:0]  duty_r, duty_nxt;

  logic                         accept;
  logic                         proc;
  logic                         same;
  logic                         step_up;
  logic                         step_down;
  logic signed [PROD_W-1:0]     scale_ext;
  logic signed [PROD_W-1:0]     prod_calc;
  logic signed [ERR_W-1:0]      err;
  logic signed [ERR_W-1:0]      band_q;
  logic                         err_low;
  logic                         err_high;
  logic                         err_edge;
  logic [LVL_W:0]               credit_used;

  // Accept only when the queue has room for this item and the one in flight.
  assign credit_used   = {1'b0, q_level} + (LVL_W + 1)'(item_v_r);
  assign in_chan.ready = !recalc_r &&
                         (credit_used <= (LVL_W + 1)'(ehph_pkg::OUT_Q_DEPTH - 2));
  assign accept        = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  // The held item is processed unless the product is being rebuilt.
  assign proc       = item_v_r && !recalc_r;
  assign item_v_nxt = accept ? 1'b1 : (proc ? 1'b0 : item_v_r);

  // Quadrature direction of the edge.
  assign same      = (lvl_a_r == lvl_b_r);
  assign step_up   = ((mode_r == ehph_pkg::MODE_EDGE_A) && same) ||
                     ((mode_r == ehph_pkg::MODE_EDGE_B) && !same);
  assign step_down = ((mode_r == ehph_pkg::MODE_EDGE_A) && !same) ||
                     ((mode_r == ehph_pkg::MODE_EDGE_B) && same);

  // Full product, used only after a scale write.
  assign scale_ext = $signed({{(PROD_W - ehph_pkg::SCALE_W){1'b0}}, scale_r});
  assign prod_calc = count_r * $signed({1'b0, scale_r});

  // Angle error in Q16 against the deadband.
  assign err    = $signed({{(ERR_W - TGT_W){1'b0}}, target_r, {ehph_pkg::FRAC_W{1'b0}}})
                - $signed({prod_r[PROD_W-1], prod_r});
  assign band_q = $signed({{(ERR_W - BQ_W){1'b0}}, band_r, {ehph_pkg::FRAC_W{1'b0}}});
  assign err_low  = err < -band_q;
  assign err_high = err > band_q;
  assign err_edge = (err == band_q) || (err == -band_q);

  // Next state for one item, or the product rebuild after a scale write.
  always_comb begin
    count_nxt = count_r;
    prod_nxt  = prod_r;
    phase_nxt = phase_r;
    dir_nxt   = dir_r;
    duty_nxt  = duty_r;
    if (recalc_r) begin
      prod_nxt = prod_calc;
    end else if (proc) begin
      if (step_up && (count_r != POS_MAX)) begin
        count_nxt = count_r + PW'(1);
        prod_nxt  = prod_r + scale_ext;
      end else if (step_down && (count_r != POS_MIN)) begin
        count_nxt = count_r - PW'(1);
        prod_nxt  = prod_r - scale_ext;
      end
      if (mode_r == ehph_pkg::MODE_TICK) begin
        case (phase_r)
          ehph_pkg::PH_HOMING: begin
            dir_nxt  = 1'b1;
            duty_nxt = home_duty_r;
            if (switch_r) begin
              count_nxt = '0;
              prod_nxt  = '0;
              phase_nxt = ehph_pkg::PH_ARMING;
            end
          end
          ehph_pkg::PH_ARMING: begin
            phase_nxt = ehph_pkg::PH_HOLDING;
          end
          ehph_pkg::PH_HOLDING: begin
            if (err_low) begin
              dir_nxt  = 1'b1;
              duty_nxt = drive_duty_r;
            end else if (err_high) begin
              dir_nxt  = 1'b0;
              duty_nxt = drive_duty_r;
            end else if (!err_edge) begin
              dir_nxt  = 1'b1;
              duty_nxt = '0;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  assign res_push = proc;
  assign res_data = {dir_nxt, duty_nxt, ehph_pkg::phase_code(phase_nxt), count_nxt};

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r     <= 1'b0;
      recalc_r     <= 1'b0;
      count_r      <= '0;
      prod_r       <= '0;
      phase_r      <= ehph_pkg::PH_HOMING;
      dir_r        <= 1'b0;
      duty_r       <= '0;
      target_r     <= ehph_pkg::TARGET_ANGLE_RST;
      band_r       <= ehph_pkg::DEADBAND_RST;
      drive_duty_r <= ehph_pkg::DRIVE_DUTY_RST;
      home_duty_r  <= ehph_pkg::HOME_DUTY_RST;
      scale_r      <= ehph_pkg::SCALE_RST;
    end else begin
      item_v_r <= item_v_nxt;
      count_r  <= count_nxt;
      prod_r   <= prod_nxt;
      phase_r  <= phase_nxt;
      dir_r    <= dir_nxt;
      duty_r   <= duty_nxt;
      recalc_r <= cfg_chan.valid && (cfg_chan.index == ehph_pkg::REG_SCALE);
      if (cfg_chan.valid) begin
        case (cfg_chan.index)
          ehph_pkg::REG_TARGET_ANGLE: target_r     <= cfg_chan.data[ehph_pkg::ANGLE_W-1:0];
          ehph_pkg::REG_DEADBAND:     band_r       <= cfg_chan.data[ehph_pkg::BAND_W-1:0];
          ehph_pkg::REG_DRIVE_DUTY:   drive_duty_r <= cfg_chan.data[ehph_pkg::DUTY_W-1:0];
          ehph_pkg::REG_HOME_DUTY:    home_duty_r  <= cfg_chan.data[ehph_pkg::DUTY_W-1:0];
          ehph_pkg::REG_SCALE:        scale_r      <= cfg_chan.data[ehph_pkg::SCALE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Input payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= in_chan.mode;
      lvl_a_r  <= in_chan.level_a;
      lvl_b_r  <= in_chan.level_b;
      switch_r <= in_chan.home_switch;
    end
  end

  // The running product matches the count whenever no rebuild is pending.
  a_prod_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    !recalc_r |-> prod_r == prod_calc)
    else $error("running product out of step with count");

  // An item held during a rebuild is kept, not dropped.
  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    recalc_r && item_v_r |=> item_v_r)
    else $error("item dropped during product rebuild");

  // Homing with the switch pressed clears the position.
  a_home_clear: assert property (@(posedge clk) disable iff (!rst_n)
    proc && (mode_r == ehph_pkg::MODE_TICK) && (phase_r == ehph_pkg::PH_HOMING) && switch_r
    |=> count_r == '0)
    else $error("homing did not clear position");

  // The count sticks at its upper limit.
  a_sat_high: assert property (@(posedge clk) disable iff (!rst_n)
    proc && step_up && (count_r == POS_MAX) |=> count_r == POS_MAX)
    else $error("position wrapped past upper limit");

endmodule

// ----- src/encoder_homing_position_hold.sv -----
// Channel   Direction  Transaction
// in_chan   sink       one A edge, B edge or control tick, with pin and switch levels
// out_chan  source     drive direction, duty, phase and position after that event
// cfg_chan  sink       register index and value, applied at once
//
// An accepted event's result is pushed from the input register into the output queue,
// unless a scale rebuild holds it; a new event is taken every cycle while ready is high.
// A write to the scale register rebuilds the stored position product in the
// following cycle, during which no event is taken.
// Reset is synchronous and active low; control and config registers return to defaults.
// A four-entry result queue absorbs output stalls; input ready drops once the
// queued results plus the held event exceed two.
module encoder_homing_position_hold #(
  parameter int POSITION_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  ehph_in_if.sink     in_chan,
  ehph_out_if.source  out_chan,
  ehph_cfg_if.sink    cfg_chan
);

  localparam int LVL_W = $clog2(ehph_pkg::OUT_Q_DEPTH + 1);
  localparam int RES_W = 1 + ehph_pkg::DUTY_W + ehph_pkg::PHASE_W + POSITION_WIDTH;

  logic             res_push;
  logic [RES_W-1:0] res_data;
  logic [RES_W-1:0] q_data;
  logic [LVL_W-1:0] q_level;

  // Event processing and controller state.
  ehph_core #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg_chan (cfg_chan),
    .q_level  (q_level),
    .res_push (res_push),
    .res_data (res_data)
  );

  // Result queue in front of the output channel.
  ehph_out_q #(
    .WIDTH (RES_W),
    .DEPTH (ehph_pkg::OUT_Q_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .pop_valid (out_chan.valid),
    .pop_ready (out_chan.ready),
    .pop_data  (q_data),
    .level     (q_level)
  );

  // Split the queue entry into the result fields.
  assign out_chan.direction = q_data[RES_W-1];
  assign out_chan.duty      = q_data[RES_W-2 -: ehph_pkg::DUTY_W];
  assign out_chan.phase     = q_data[POSITION_WIDTH +: ehph_pkg::PHASE_W];
  assign out_chan.position  = $signed(q_data[POSITION_WIDTH-1:0]);

endmodule

// ----- tb/sv/encoder_homing_position_hold_tb.sv -----
`timescale 1ns / 1ps

module encoder_homing_position_hold_tb;
  import ehph_pkg::*;

  localparam int     POS_W          = 24;
  localparam longint POS_MAX        = (longint'(1) << (POS_W - 1)) - 1;
  localparam longint POS_MIN        = -POS_MAX - 1;
  localparam longint FIXED_ONE      = longint'(1) << FRAC_W;
  localparam int     NUM_PHASES     = 7;
  localparam int     ITEMS_PER_PHASE = 190;
  localparam longint MAX_WALK       = 60;
  localparam int     LIMIT_CYCLES   = 200000;
  localparam int     SETTLE_CYCLES  = 6;

  // Mode code that the block must ignore, and register indexes with no register.
  localparam logic [MODE_W-1:0]    MODE_UNUSED     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              level_a;
    logic              level_b;
    logic              home_switch;
  } encoder_item_t;

  typedef struct {
    logic                    direction;
    logic [DUTY_W-1:0]       duty;
    logic [PHASE_W-1:0]      phase;
    logic signed [POS_W-1:0] position;
  } drive_result_t;

  typedef enum {SINK_OPEN, SINK_HALF, SINK_LIGHT, SINK_BURSTY} sink_style_t;

  logic clk = 1'b0;
  logic rst_n;

  ehph_in_if                           in_if();
  ehph_out_if #(.POSITION_WIDTH(POS_W)) out_if();
  ehph_cfg_if                          cfg_if();

  encoder_homing_position_hold #(.POSITION_WIDTH(POS_W)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // Clock generation.
  always #5 clk = ~clk;

  // Predicted register file and controller state.
  logic [ANGLE_W-1:0] cfg_target   = TARGET_ANGLE_RST;
  logic [BAND_W-1:0]  cfg_deadband = DEADBAND_RST;
  logic [DUTY_W-1:0]  cfg_drive    = DRIVE_DUTY_RST;
  logic [DUTY_W-1:0]  cfg_home     = HOME_DUTY_RST;
  logic [SCALE_W-1:0] cfg_scale    = SCALE_RST;

  longint             model_count = 0;
  logic [PHASE_W-1:0] model_phase = PHASE_CODE_HOMING;
  logic               model_dir   = 1'b0;
  logic [DUTY_W-1:0]  model_duty  = '0;

  encoder_item_t pending_events[$];
  drive_result_t expected_drive_q[$];

  // Stimulus bookkeeping and statistics.
  longint      gen_count = 0;
  bit          in_taken = 1'b0;
  int          burst_left = 8;
  int          gap_left = 0;
  int          stall_left = 0;
  sink_style_t sink_style = SINK_OPEN;
  int          cycle_count = 0;
  int          mismatches = 0;
  int          items_sent = 0;
  int          results_checked = 0;
  int          cfg_writes = 0;
  int          settings_run = 0;
  int          hold_dir1 = 0;
  int          hold_dir0 = 0;
  int          hold_stop = 0;
  int          hold_kept = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // Steps the predicted controller by one accepted transaction and queues its result.
  task automatic advance_drive_model(input logic [MODE_W-1:0] mode, input logic la,
                                     input logic lb, input logic sw);
    longint        nxt;
    longint        err;
    longint        band;
    drive_result_t res;
    nxt = model_count;
    case (mode)
      MODE_EDGE_A: nxt = model_count + ((la == lb) ? 1 : -1);
      MODE_EDGE_B: nxt = model_count + ((la == lb) ? -1 : 1);
      MODE_TICK: begin
        case (model_phase)
          PHASE_CODE_HOMING: begin
            model_dir  = 1'b1;
            model_duty = cfg_home;
            if (sw) begin
              nxt = 0;
              model_phase = PHASE_CODE_ARMING;
            end
          end
          PHASE_CODE_ARMING: model_phase = PHASE_CODE_HOLDING;
          PHASE_CODE_HOLDING: begin
            err  = longint'(cfg_target) * FIXED_ONE - model_count * longint'(cfg_scale);
            band = longint'(cfg_deadband) * FIXED_ONE;
            if (err < -band) begin
              model_dir  = 1'b1;
              model_duty = cfg_drive;
              hold_dir1++;
            end else if (err > band) begin
              model_dir  = 1'b0;
              model_duty = cfg_drive;
              hold_dir0++;
            end else if (err > -band && err < band) begin
              model_dir  = 1'b1;
              model_duty = '0;
              hold_stop++;
            end else begin
              // On the band edge the drive keeps its previous setting.
              hold_kept++;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (nxt > POS_MAX) nxt = POS_MAX;
    if (nxt < POS_MIN) nxt = POS_MIN;
    model_count = nxt;
    res.direction = model_dir;
    res.duty      = model_duty;
    res.phase     = model_phase;
    res.position  = model_count[POS_W-1:0];
    expected_drive_q.push_back(res);
  endtask

  // Output check first, then prediction for the input transaction of the same edge.
  always @(posedge clk) begin : monitor
    drive_result_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_drive_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, position %0d",
                                  out_if.position));
      end else begin
        want = expected_drive_q.pop_front();
        if (out_if.direction !== want.direction)
          report_mismatch($sformatf("result %0d direction %b, expected %b",
                                    results_checked, out_if.direction, want.direction));
        if (out_if.duty !== want.duty)
          report_mismatch($sformatf("result %0d duty %0d, expected %0d",
                                    results_checked, out_if.duty, want.duty));
        if (out_if.phase !== want.phase)
          report_mismatch($sformatf("result %0d phase %0d, expected %0d",
                                    results_checked, out_if.phase, want.phase));
        if (out_if.position !== want.position)
          report_mismatch($sformatf("result %0d position %0d, expected %0d",
                                    results_checked, out_if.position, want.position));
        results_checked++;
      end
    end
    in_taken = (rst_n === 1'b1 && in_if.valid === 1'b1 && in_if.ready === 1'b1);
    if (in_taken) begin
      advance_drive_model(in_if.mode, in_if.level_a, in_if.level_b, in_if.home_switch);
      items_sent++;
    end
  end

  // Cycle counter and watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding.", cycle_count,
               expected_drive_q.size());
      $display("encoder_homing_position_hold verification failed");
      $finish;
    end
  end

  // Input driver: bursts of transactions separated by random gaps.
  always @(negedge clk) begin : driver
    encoder_item_t nxt;
    if (rst_n !== 1'b1) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (gap_left > 0 || pending_events.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_if.valid <= 1'b0;
      end else begin
        nxt = pending_events.pop_front();
        in_if.valid       <= 1'b1;
        in_if.mode        <= nxt.mode;
        in_if.level_a     <= nxt.level_a;
        in_if.level_b     <= nxt.level_b;
        in_if.home_switch <= nxt.home_switch;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Result receiver: the ready pattern follows a randomly redrawn stall style.
  always @(negedge clk) begin : sink_pattern
    if (cycle_count % 300 == 0) sink_style = sink_style_t'($urandom_range(0, 3));
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (sink_style)
        SINK_OPEN: out_if.ready <= 1'b1;
        SINK_HALF: out_if.ready <= ($urandom_range(0, 1) == 1);
        SINK_LIGHT: out_if.ready <= ($urandom_range(0, 4) != 0);
        default: begin
          if ($urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(3, 12);
            out_if.ready <= 1'b0;
          end else begin
            out_if.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  task automatic push_item(input logic [MODE_W-1:0] mode, input logic la, input logic lb,
                           input logic sw);
    encoder_item_t it;
    it.mode        = mode;
    it.level_a     = la;
    it.level_b     = lb;
    it.home_switch = sw;
    if (mode == MODE_EDGE_A) gen_count += (la == lb) ? 1 : -1;
    if (mode == MODE_EDGE_B) gen_count += (la == lb) ? -1 : 1;
    pending_events.push_back(it);
  endtask

  // One quadrature edge that moves the count by dir, on a random channel.
  task automatic push_step(input int dir);
    logic [MODE_W-1:0] mode;
    logic              la;
    logic              same;
    mode = $urandom_range(0, 1) ? MODE_EDGE_B : MODE_EDGE_A;
    la   = 1'($urandom_range(0, 1));
    same = (mode == MODE_EDGE_A) ? (dir > 0) : (dir < 0);
    push_item(mode, la, same ? la : ~la, 1'($urandom_range(0, 1)));
  endtask

  task automatic push_tick();
    push_item(MODE_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic push_noise();
    push_item(MODE_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // Walks the count toward a point near the stop band and dithers across it with ticks.
  task automatic plan_hold_segment();
    longint band;
    longint band_err;
    longint goal;
    int     n;
    band = longint'(cfg_deadband) * FIXED_ONE;
    case ($urandom_range(0, 3))
      0: band_err = band;
      1: band_err = -band;
      2: band_err = 0;
      default: band_err = longint'($urandom_range(0, int'(2 * band))) - band;
    endcase
    if (cfg_scale == '0)
      goal = gen_count + longint'($urandom_range(0, 40)) - 20;
    else
      goal = (longint'(cfg_target) * FIXED_ONE - band_err) / longint'(cfg_scale);
    goal += longint'($urandom_range(0, 6)) - 3;
    if (goal > gen_count + MAX_WALK) goal = gen_count + MAX_WALK;
    if (goal < gen_count - MAX_WALK) goal = gen_count - MAX_WALK;
    while (gen_count != goal) begin
      push_step((goal > gen_count) ? 1 : -1);
      if ($urandom_range(0, 9) < 4) push_tick();
      if ($urandom_range(0, 9) == 0) push_noise();
    end
    n = $urandom_range(2, 6);
    repeat (n) begin
      push_tick();
      push_step($urandom_range(0, 1) ? 1 : -1);
    end
    push_tick();
  endtask

  // Register write over the configuration channel; the model follows on acceptance.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    case (idx)
      REG_TARGET_ANGLE: cfg_target   = data[ANGLE_W-1:0];
      REG_DEADBAND:     cfg_deadband = data[BAND_W-1:0];
      REG_DRIVE_DUTY:   cfg_drive    = data[DUTY_W-1:0];
      REG_HOME_DUTY:    cfg_home     = data[DUTY_W-1:0];
      REG_SCALE:        cfg_scale    = data[SCALE_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic load_setting(input logic [CFG_DATA_W-1:0] target,
                              input logic [CFG_DATA_W-1:0] band,
                              input logic [CFG_DATA_W-1:0] drive,
                              input logic [CFG_DATA_W-1:0] home,
                              input logic [CFG_DATA_W-1:0] scale);
    write_register(REG_TARGET_ANGLE, target);
    write_register(REG_DEADBAND, band);
    write_register(REG_DRIVE_DUTY, drive);
    write_register(REG_HOME_DUTY, home);
    write_register(REG_SCALE, scale);
    settings_run++;
  endtask

  // Waits for every queued transaction to be sent and every result to arrive.
  task automatic settle();
    while (pending_events.size() != 0 || in_if.valid === 1'b1 ||
           expected_drive_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    gen_count = model_count;
  endtask

  initial begin : stimulus
    logic [SCALE_W-1:0] rnd_scale;
    in_if.valid       = 1'b0;
    in_if.mode        = MODE_EDGE_A;
    in_if.level_a     = 1'b0;
    in_if.level_b     = 1'b0;
    in_if.home_switch = 1'b0;
    out_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = REG_TARGET_ANGLE;
    cfg_if.data       = '0;
    rst_n             = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Homing with the reset register values: edges of every level combination on
    // both channels, the ignored mode, then the switch press and the arming tick.
    push_item(MODE_TICK,   1'b0, 1'b0, 1'b0);
    push_item(MODE_EDGE_A, 1'b0, 1'b0, 1'b0);
    push_item(MODE_EDGE_A, 1'b0, 1'b1, 1'b1);
    push_item(MODE_EDGE_A, 1'b1, 1'b0, 1'b0);
    push_item(MODE_EDGE_A, 1'b1, 1'b1, 1'b1);
    push_item(MODE_EDGE_B, 1'b0, 1'b0, 1'b0);
    push_item(MODE_EDGE_B, 1'b0, 1'b1, 1'b0);
    push_item(MODE_EDGE_B, 1'b1, 1'b0, 1'b1);
    push_item(MODE_EDGE_B, 1'b1, 1'b1, 1'b0);
    push_item(MODE_EDGE_A, 1'b1, 1'b1, 1'b0);
    push_item(MODE_UNUSED, 1'b1, 1'b0, 1'b1);
    push_item(MODE_TICK,   1'b0, 1'b1, 1'b1);
    push_item(MODE_TICK,   1'b1, 1'b1, 1'b0);
    settle();

    // Quarter-degree counts and a one-degree band: a zero count sits on the band edge,
    // one count below is outside it and one count above is inside it.
    load_setting(16'd1, 16'd1, 16'd90, 16'd200, 16'd16384);
    push_item(MODE_TICK,   1'b0, 1'b0, 1'b0);
    push_item(MODE_EDGE_A, 1'b1, 1'b0, 1'b0);
    push_item(MODE_TICK,   1'b0, 1'b0, 1'b0);
    push_item(MODE_EDGE_B, 1'b0, 1'b1, 1'b0);
    push_item(MODE_EDGE_B, 1'b1, 1'b0, 1'b0);
    push_item(MODE_TICK,   1'b1, 1'b0, 1'b0);
    push_item(MODE_TICK,   1'b1, 1'b1, 1'b1);
    push_item(MODE_UNUSED, 1'b1, 1'b1, 1'b1);
    settle();

    // Random holding traffic under a series of register settings.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: load_setting(16'd45, 16'd2, 16'd25, 16'd25, 16'd39361);
        1: load_setting(16'd0, 16'd0, 16'd0, 16'd255, 16'd65535);
        2: load_setting(16'd360, 16'd15, 16'd255, 16'd0, 16'd16384);
        3: begin
          // Upper data bits set on every register narrower than the data word, plus unmapped writes.
          load_setting(16'hFFFF, 16'hFFF7, 16'hFF80, 16'h1234, 16'd1);
          write_register(REG_UNMAPPED_LO, 16'($urandom));
          write_register(REG_UNMAPPED_HI, 16'($urandom));
        end
        4: load_setting(16'd180, 16'd5, 16'd200, 16'd77, 16'd0);
        default: begin
          case ($urandom_range(0, 4))
            0: rnd_scale = 16'd16384;
            1: rnd_scale = 16'd32768;
            2: rnd_scale = 16'd8192;
            3: rnd_scale = 16'd4096;
            default: rnd_scale = 16'($urandom_range(1, 65535));
          endcase
          load_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       rnd_scale);
        end
      endcase
      gen_count = model_count;
      while (pending_events.size() < ITEMS_PER_PHASE) plan_hold_segment();
      settle();
    end

    $display("Run covered %0d transactions and %0d checked results",
             items_sent, results_checked);
    $display("under %0d settings (%0d register writes).", settings_run, cfg_writes);
    $display("Holding ticks: %0d drove dir 1, %0d drove dir 0, %0d stopped,",
             hold_dir1, hold_dir0, hold_stop);
    $display("%0d held on a band edge.", hold_kept);
    if (mismatches == 0) begin
      $display("encoder_homing_position_hold verification clean");
    end else begin
      $display("%0d mismatches.", mismatches);
      $display("encoder_homing_position_hold verification failed");
    end
    $finish;
  end

endmodule
